@@ src/stcb_pkg.sv @@
package stcb_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // unit vectors are carried as Q2.30
    localparam int UNIT_BITS = 30;
    localparam int ROOT_W    = UNIT_BITS + 1;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int LANES     = 3;

    localparam logic [ROOT_W-1:0] UNIT_ONE = ROOT_W'(64'd1 << UNIT_BITS);
    localparam logic [ROOT_W-1:0] Y_LIMIT  = ROOT_W'(((64'd1 << UNIT_BITS) * 64'd999) / 64'd1000);
    localparam logic [SQ_W-1:0]   T_EPS_SQ = SQ_W'((64'd1 << 60) / 64'd1000000000000);

    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [SQ_W-1:0] sq_t;
    typedef logic [REM_W-1:0] rem_t;
    typedef logic [LANES-1:0][ROOT_W-1:0] lane_vec_t;

endpackage

@@ src/stcb_sqrt_cell.sv @@
module stcb_sqrt_cell (
    input  logic            clk,
    input  stcb_pkg::rem_t  rem_in,
    input  stcb_pkg::root_t root_in,
    input  stcb_pkg::sq_t   x_in,
    output stcb_pkg::rem_t  rem_out,
    output stcb_pkg::root_t root_out,
    output stcb_pkg::sq_t   x_out
);

    stcb_pkg::rem_t  rem_reg, rem_next;
    stcb_pkg::root_t root_reg, root_next;
    stcb_pkg::sq_t   x_reg, x_next;

    // one root bit per cell: bring down two radicand bits, try (root << 2) | 1
    always_comb
    begin
        logic [stcb_pkg::REM_W-1:0] shifted;
        logic [stcb_pkg::REM_W-1:0] trial;
        logic ge;
        shifted = {rem_in[stcb_pkg::REM_W-3:0], x_in[stcb_pkg::SQ_W-1 -: 2]};
        trial   = {root_in, 2'b01};
        ge      = (shifted >= trial);
        rem_next  = ge ? (shifted - trial) : shifted;
        root_next = {root_in[stcb_pkg::ROOT_W-2:0], ge};
        x_next    = {x_in[stcb_pkg::SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign x_out    = x_reg;

endmodule

@@ src/stcb_div_cell.sv @@
module stcb_div_cell (
    input  logic                clk,
    input  stcb_pkg::root_t     den_in,
    input  stcb_pkg::lane_vec_t rem_in,
    input  stcb_pkg::lane_vec_t num_in,
    input  stcb_pkg::lane_vec_t quo_in,
    output stcb_pkg::root_t     den_out,
    output stcb_pkg::lane_vec_t rem_out,
    output stcb_pkg::lane_vec_t num_out,
    output stcb_pkg::lane_vec_t quo_out
);

    stcb_pkg::root_t     den_reg;
    stcb_pkg::lane_vec_t rem_reg, rem_next;
    stcb_pkg::lane_vec_t num_reg, num_next;
    stcb_pkg::lane_vec_t quo_reg, quo_next;

    // one quotient bit per cell for all three lanes, shared divisor
    always_comb
    begin
        logic [stcb_pkg::ROOT_W:0] part;
        logic [stcb_pkg::ROOT_W:0] diff;
        logic ge;
        for (int i = 0; i < stcb_pkg::LANES; i++)
        begin
            part = {rem_in[i], num_in[i][stcb_pkg::ROOT_W-1]};
            diff = part - {1'b0, den_in};
            ge   = (part >= {1'b0, den_in});
            rem_next[i] = ge ? diff[stcb_pkg::ROOT_W-1:0] : part[stcb_pkg::ROOT_W-1:0];
            num_next[i] = {num_in[i][stcb_pkg::ROOT_W-2:0], 1'b0};
            quo_next[i] = {quo_in[i][stcb_pkg::ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_in;
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;

endmodule

@@ src/stcb_delay.sv @@
module stcb_delay #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  logic [DATA_W-1:0] data_in,
    output logic              vld_out,
    output logic [DATA_W-1:0] data_out
);

    logic              vld_reg  [DEPTH];
    logic [DATA_W-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= vld_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= data_in;
        for (int k = 1; k < DEPTH; k++)
        begin
            data_reg[k] <= data_reg[k-1];
        end
    end

    assign vld_out  = vld_reg[DEPTH-1];
    assign data_out = data_reg[DEPTH-1];

endmodule

@@ src/segment_to_cylinder_basis.sv @@
// segment to cylinder basis: placement matrix of a unit cylinder on a 3-d segment
//
// input beat: start_*, end_*, tube_radius, taken on a clock edge with start high
// and busy low. busy stays low: a new beat may be taken on every cycle.
// result beat: side_*, span_*, normal_*, center_*, valid for one cycle with done.
// throughput is one beat per cycle. the pipeline is built from the two 31-cell
// square-root rows and the two 31-cell divider rows (one result bit per cell),
// plus 16 arithmetic stages.
// results leave in input order; the receiver cannot stall, so nothing backs up.
// reset clears all valid flags: beats in flight are dropped and done stays low
// until a new beat has run the full pipeline.
// a segment of zero length gives diag(radius, 1, radius) at the midpoint.
module segment_to_cylinder_basis #(
    parameter int WORD_BITS = stcb_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = stcb_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] start_x,
    input  logic [WORD_BITS-1:0] start_y,
    input  logic [WORD_BITS-1:0] start_z,
    input  logic [WORD_BITS-1:0] end_x,
    input  logic [WORD_BITS-1:0] end_y,
    input  logic [WORD_BITS-1:0] end_z,
    input  logic [WORD_BITS-2:0] tube_radius,
    output logic                 done,
    output logic [WORD_BITS-1:0] side_x,
    output logic [WORD_BITS-1:0] side_y,
    output logic [WORD_BITS-1:0] side_z,
    output logic [WORD_BITS-1:0] span_x,
    output logic [WORD_BITS-1:0] span_y,
    output logic [WORD_BITS-1:0] span_z,
    output logic [WORD_BITS-1:0] normal_x,
    output logic [WORD_BITS-1:0] normal_y,
    output logic [WORD_BITS-1:0] normal_z,
    output logic [WORD_BITS-1:0] center_x,
    output logic [WORD_BITS-1:0] center_y,
    output logic [WORD_BITS-1:0] center_z
);

    localparam int W     = WORD_BITS;
    localparam int UB    = stcb_pkg::UNIT_BITS;
    localparam int RW    = stcb_pkg::ROOT_W;
    localparam int NL    = stcb_pkg::LANES;
    localparam int EPS_INT = int'((64'd1 << FRAC_BITS) / 64'd1000000);
    localparam int EPS_W = $clog2(EPS_INT + 1) + 1;
    localparam int SH_W  = $clog2(W + UB);
    localparam int PW    = 32 + W - 1;
    localparam int MW    = PW - UB + 1;

    localparam logic [W:0] EPS_RAW = (W+1)'(EPS_INT);
    localparam logic [2*EPS_W+1:0] EPS_SQ = (2*EPS_W+2)'(EPS_INT * EPS_INT);
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SPAN_ONE = (FRAC_BITS >= W - 1) ? SMAX : W'(64'd1 << FRAC_BITS);
    localparam logic [SH_W-1:0] NORM_POS = SH_W'(UB - 1);

    typedef struct packed {
        logic                zero;
        logic [NL-1:0]       neg;
        logic [NL-1:0][W-1:0] span;
        logic [NL-1:0][W-1:0] ctr;
        logic [W-2:0]        rad;
    } sb_t;

    typedef struct packed {
        sb_t                  sb;
        logic [NL-1:0][UB-1:0] a;
    } lsb_t;

    typedef struct packed {
        sb_t                  sb;
        logic [NL-1:0][31:0]  u;
        logic [NL-1:0][RW-1:0] tmag;
        logic [NL-1:0]        tneg;
        logic                 deg;
    } tsb_t;

    function automatic logic [W-1:0] sat_mag(input logic [MW-1:0] m, input logic neg);
        logic [W-1:0] low;
        low = m[W-1:0];
        if (m >= (MW'(1) << (W - 1)))
        begin
            return neg ? SMIN : SMAX;
        end
        return neg ? (~low + 1'b1) : low;
    endfunction

    logic acc;
    assign busy = 1'b0;
    assign acc  = start && !busy;

    logic [W-1:0] s_in [NL];
    logic [W-1:0] e_in [NL];
    assign s_in[0] = start_x;
    assign s_in[1] = start_y;
    assign s_in[2] = start_z;
    assign e_in[0] = end_x;
    assign e_in[1] = end_y;
    assign e_in[2] = end_z;

    // valid flags of the explicit stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic vd0_reg, vt1_reg, vt2_reg, vt3_reg, vd2_reg, vt4_reg;
    logic vx1_reg, vx2_reg, vr1_reg, done_reg;
    logic vq1, vdv1, vq2, vdv2;

    // stage 1: difference and midpoint
    logic [NL-1:0][W:0]   d1_reg, d1_next;
    logic [NL-1:0][W-1:0] c1_reg, c1_next;
    logic [W-2:0]         r1_reg;

    always_comb
    begin
        logic [W:0] sx;
        logic [W:0] ex;
        logic [W:0] sum;
        for (int i = 0; i < NL; i++)
        begin
            sx = {s_in[i][W-1], s_in[i]};
            ex = {e_in[i][W-1], e_in[i]};
            sum = ex + sx;
            d1_next[i] = ex - sx;
            c1_next[i] = sum[W:1];
        end
    end

    // stage 2: magnitudes, largest component, zero-length test, span clamp
    logic [NL-1:0][W:0] mag2_reg, mag2_next;
    logic [W:0]         mx2_reg, mx2_next;
    sb_t                sb2_reg, sb2_next;

    always_comb
    begin
        logic [2*EPS_W+1:0] sumsq;
        logic [EPS_W-1:0] lo;
        sumsq = '0;
        mx2_next = '0;
        for (int i = 0; i < NL; i++)
        begin
            sb2_next.neg[i] = d1_reg[i][W];
            mag2_next[i] = d1_reg[i][W] ? (~d1_reg[i] + 1'b1) : d1_reg[i];
            if (mag2_next[i] > mx2_next)
            begin
                mx2_next = mag2_next[i];
            end
            lo = mag2_next[i][EPS_W-1:0];
            sumsq = sumsq + (2*EPS_W+2)'(lo) * (2*EPS_W+2)'(lo);
            if (!d1_reg[i][W] && d1_reg[i][W-1])
            begin
                sb2_next.span[i] = SMAX;
            end
            else if (d1_reg[i][W] && !d1_reg[i][W-1])
            begin
                sb2_next.span[i] = SMIN;
            end
            else
            begin
                sb2_next.span[i] = d1_reg[i][W-1:0];
            end
        end
        sb2_next.zero = (mx2_next <= EPS_RAW) && (sumsq <= EPS_SQ);
        sb2_next.ctr  = c1_reg;
        sb2_next.rad  = r1_reg;
    end

    // stage 3: shift that brings the largest component to [2^29, 2^30)
    logic [NL-1:0][W:0] mag3_reg;
    logic [SH_W-1:0]    sh3_reg, sh3_next;
    logic               left3_reg, left3_next;
    sb_t                sb3_reg;

    always_comb
    begin
        logic [SH_W-1:0] pos;
        pos = '0;
        for (int j = 0; j <= W; j++)
        begin
            if (mx2_reg[j])
            begin
                pos = SH_W'(j);
            end
        end
        left3_next = (pos < NORM_POS);
        sh3_next   = left3_next ? (NORM_POS - pos) : (pos - NORM_POS);
    end

    // stage 4: rescaled components
    logic [NL-1:0][UB-1:0] a4_reg, a4_next;
    sb_t                   sb4_reg;

    always_comb
    begin
        logic [W+UB:0] wide;
        logic [W+UB:0] moved;
        for (int i = 0; i < NL; i++)
        begin
            wide  = {{UB{1'b0}}, mag3_reg[i]};
            moved = left3_reg ? (wide << sh3_reg) : (wide >> sh3_reg);
            a4_next[i] = moved[UB-1:0];
        end
    end

    // stage 5 squares, stage 6 squared length
    logic [NL-1:0][2*UB-1:0] sq5_reg;
    logic [NL-1:0][UB-1:0]   a5_reg;
    sb_t                     sb5_reg;
    stcb_pkg::sq_t           lsq6_reg;
    lsb_t                    lsb6_reg;

    always_ff @(posedge clk)
    begin
        d1_reg <= d1_next;
        c1_reg <= c1_next;
        r1_reg <= tube_radius;
        mag2_reg <= mag2_next;
        mx2_reg  <= mx2_next;
        sb2_reg  <= sb2_next;
        mag3_reg  <= mag2_reg;
        sh3_reg   <= sh3_next;
        left3_reg <= left3_next;
        sb3_reg   <= sb2_reg;
        a4_reg  <= a4_next;
        sb4_reg <= sb3_reg;
        for (int i = 0; i < NL; i++)
        begin
            sq5_reg[i] <= a4_reg[i] * a4_reg[i];
        end
        a5_reg  <= a4_reg;
        sb5_reg <= sb4_reg;
        lsq6_reg <= stcb_pkg::SQ_W'(sq5_reg[0]) + stcb_pkg::SQ_W'(sq5_reg[1])
                  + stcb_pkg::SQ_W'(sq5_reg[2]);
        lsb6_reg.sb <= sb5_reg;
        lsb6_reg.a  <= a5_reg;
    end

    // first square-root row: length of the rescaled difference
    stcb_pkg::rem_t  q1_rem  [RW+1];
    stcb_pkg::root_t q1_root [RW+1];
    stcb_pkg::sq_t   q1_x    [RW+1];
    lsb_t            lsb_q1;

    assign q1_rem[0]  = '0;
    assign q1_root[0] = '0;
    assign q1_x[0]    = lsq6_reg;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt1
        stcb_sqrt_cell u_cell (
            .clk      (clk),
            .rem_in   (q1_rem[k]),
            .root_in  (q1_root[k]),
            .x_in     (q1_x[k]),
            .rem_out  (q1_rem[k+1]),
            .root_out (q1_root[k+1]),
            .x_out    (q1_x[k+1])
        );
    end

    stcb_delay #(.DATA_W($bits(lsb_t)), .DEPTH(RW)) u_dly_q1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (v6_reg),
        .data_in  (lsb6_reg),
        .vld_out  (vq1),
        .data_out (lsb_q1)
    );

    // divider setup: numerator a * 2^30 + len / 2, rounds the quotient
    stcb_pkg::root_t     den0_reg;
    stcb_pkg::lane_vec_t rem0_reg, num0_reg;
    sb_t                 sbd0_reg;

    always_ff @(posedge clk)
    begin
        logic [stcb_pkg::SQ_W-1:0] nn;
        for (int i = 0; i < NL; i++)
        begin
            nn = (stcb_pkg::SQ_W'(lsb_q1.a[i]) << UB)
               + stcb_pkg::SQ_W'(q1_root[RW][RW-1:1]);
            rem0_reg[i] <= nn[stcb_pkg::SQ_W-1:RW];
            num0_reg[i] <= nn[RW-1:0];
        end
        den0_reg <= q1_root[RW];
        sbd0_reg <= lsb_q1.sb;
    end

    // first divider row: unit direction
    stcb_pkg::root_t     dv1_den [RW+1];
    stcb_pkg::lane_vec_t dv1_rem [RW+1];
    stcb_pkg::lane_vec_t dv1_num [RW+1];
    stcb_pkg::lane_vec_t dv1_quo [RW+1];
    sb_t                 sb_dv1;

    assign dv1_den[0] = den0_reg;
    assign dv1_rem[0] = rem0_reg;
    assign dv1_num[0] = num0_reg;
    assign dv1_quo[0] = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_div1
        stcb_div_cell u_cell (
            .clk     (clk),
            .den_in  (dv1_den[k]),
            .rem_in  (dv1_rem[k]),
            .num_in  (dv1_num[k]),
            .quo_in  (dv1_quo[k]),
            .den_out (dv1_den[k+1]),
            .rem_out (dv1_rem[k+1]),
            .num_out (dv1_num[k+1]),
            .quo_out (dv1_quo[k+1])
        );
    end

    stcb_delay #(.DATA_W($bits(sb_t)), .DEPTH(RW)) u_dly_dv1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vd0_reg),
        .data_in  (sbd0_reg),
        .vld_out  (vdv1),
        .data_out (sb_dv1)
    );

    // t1: signed direction and the side vector choice
    tsb_t tt1_reg, tt1_next;

    always_comb
    begin
        stcb_pkg::lane_vec_t q;
        q = dv1_quo[RW];
        tt1_next.sb  = sb_dv1;
        tt1_next.deg = 1'b0;
        for (int i = 0; i < NL; i++)
        begin
            tt1_next.u[i] = sb_dv1.neg[i] ? (~{1'b0, q[i]} + 1'b1) : {1'b0, q[i]};
        end
        if (q[1] <= stcb_pkg::Y_LIMIT)
        begin
            // (uz, 0, -ux)
            tt1_next.tmag = {q[0], {RW{1'b0}}, q[2]};
            tt1_next.tneg = {!sb_dv1.neg[0], 1'b0, sb_dv1.neg[2]};
        end
        else
        begin
            // (0, -uz, uy)
            tt1_next.tmag = {q[1], q[2], {RW{1'b0}}};
            tt1_next.tneg = {sb_dv1.neg[1], !sb_dv1.neg[2], 1'b0};
        end
    end

    logic [NL-1:0][stcb_pkg::SQ_W-1:0] tsq2_reg;
    tsb_t                              tt2_reg;
    stcb_pkg::sq_t                     tsq3_reg;
    tsb_t                              tt3_reg;

    always_ff @(posedge clk)
    begin
        tsb_t tt3_tmp;
        tt1_reg <= tt1_next;
        for (int i = 0; i < NL; i++)
        begin
            tsq2_reg[i] <= stcb_pkg::SQ_W'(tt1_reg.tmag[i]) * stcb_pkg::SQ_W'(tt1_reg.tmag[i]);
        end
        tt2_reg <= tt1_reg;
        tsq3_reg <= tsq2_reg[0] + tsq2_reg[1] + tsq2_reg[2];
        tt3_tmp = tt2_reg;
        tt3_tmp.deg = ((tsq2_reg[0] + tsq2_reg[1] + tsq2_reg[2]) <= stcb_pkg::T_EPS_SQ);
        tt3_reg <= tt3_tmp;
    end

    // second square-root row: length of the side vector
    stcb_pkg::rem_t  q2_rem  [RW+1];
    stcb_pkg::root_t q2_root [RW+1];
    stcb_pkg::sq_t   q2_x    [RW+1];
    tsb_t            tt_q2;

    assign q2_rem[0]  = '0;
    assign q2_root[0] = '0;
    assign q2_x[0]    = tsq3_reg;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt2
        stcb_sqrt_cell u_cell (
            .clk      (clk),
            .rem_in   (q2_rem[k]),
            .root_in  (q2_root[k]),
            .x_in     (q2_x[k]),
            .rem_out  (q2_rem[k+1]),
            .root_out (q2_root[k+1]),
            .x_out    (q2_x[k+1])
        );
    end

    stcb_delay #(.DATA_W($bits(tsb_t)), .DEPTH(RW)) u_dly_q2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vt3_reg),
        .data_in  (tt3_reg),
        .vld_out  (vq2),
        .data_out (tt_q2)
    );

    stcb_pkg::root_t     den2_reg;
    stcb_pkg::lane_vec_t rem2_reg, num2_reg;
    tsb_t                ttd2_reg;

    always_ff @(posedge clk)
    begin
        logic [stcb_pkg::SQ_W-1:0] nn;
        for (int i = 0; i < NL; i++)
        begin
            nn = (stcb_pkg::SQ_W'(tt_q2.tmag[i]) << UB)
               + stcb_pkg::SQ_W'(q2_root[RW][RW-1:1]);
            rem2_reg[i] <= nn[stcb_pkg::SQ_W-1:RW];
            num2_reg[i] <= nn[RW-1:0];
        end
        den2_reg <= q2_root[RW];
        ttd2_reg <= tt_q2;
    end

    // second divider row: unit side vector
    stcb_pkg::root_t     dv2_den [RW+1];
    stcb_pkg::lane_vec_t dv2_rem [RW+1];
    stcb_pkg::lane_vec_t dv2_num [RW+1];
    stcb_pkg::lane_vec_t dv2_quo [RW+1];
    tsb_t                tt_dv2;

    assign dv2_den[0] = den2_reg;
    assign dv2_rem[0] = rem2_reg;
    assign dv2_num[0] = num2_reg;
    assign dv2_quo[0] = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_div2
        stcb_div_cell u_cell (
            .clk     (clk),
            .den_in  (dv2_den[k]),
            .rem_in  (dv2_rem[k]),
            .num_in  (dv2_num[k]),
            .quo_in  (dv2_quo[k]),
            .den_out (dv2_den[k+1]),
            .rem_out (dv2_rem[k+1]),
            .num_out (dv2_num[k+1]),
            .quo_out (dv2_quo[k+1])
        );
    end

    stcb_delay #(.DATA_W($bits(tsb_t)), .DEPTH(RW)) u_dly_dv2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vd2_reg),
        .data_in  (ttd2_reg),
        .vld_out  (vdv2),
        .data_out (tt_dv2)
    );

    // t4: final side vector, degenerate case falls back to (1,0,0)
    logic [NL-1:0][31:0]   t4_reg;
    logic [NL-1:0][RW-1:0] tm4_reg;
    logic [NL-1:0][31:0]   u4_reg;
    sb_t                   sb4t_reg;

    // x1 cross products, x2 rounded differences
    logic signed [NL-1:0][63:0] pa_reg, pb_reg;
    logic [NL-1:0][RW-1:0]      tmx1_reg;
    logic [NL-1:0]              tnx1_reg;
    logic [NL-1:0]              tn4_reg;
    sb_t                        sbx1_reg;
    logic [NL-1:0][31:0]        nm2_reg;
    logic [NL-1:0]              nn2_reg;
    logic [NL-1:0][RW-1:0]      tmx2_reg;
    logic [NL-1:0]              tnx2_reg;
    sb_t                        sbx2_reg;

    always_ff @(posedge clk)
    begin
        logic signed [63:0] sd;
        logic [63:0] smag;
        logic [63:0] rs;
        for (int i = 0; i < NL; i++)
        begin
            if (tt_dv2.deg)
            begin
                tm4_reg[i] <= (i == 0) ? stcb_pkg::UNIT_ONE : '0;
                tn4_reg[i] <= 1'b0;
                t4_reg[i]  <= (i == 0) ? {1'b0, stcb_pkg::UNIT_ONE} : '0;
            end
            else
            begin
                tm4_reg[i] <= dv2_quo[RW][i];
                tn4_reg[i] <= tt_dv2.tneg[i];
                t4_reg[i]  <= tt_dv2.tneg[i] ? (~{1'b0, dv2_quo[RW][i]} + 1'b1)
                                             : {1'b0, dv2_quo[RW][i]};
            end
        end
        u4_reg   <= tt_dv2.u;
        sb4t_reg <= tt_dv2.sb;

        pa_reg[0] <= $signed(u4_reg[1]) * $signed(t4_reg[2]);
        pb_reg[0] <= $signed(u4_reg[2]) * $signed(t4_reg[1]);
        pa_reg[1] <= $signed(u4_reg[2]) * $signed(t4_reg[0]);
        pb_reg[1] <= $signed(u4_reg[0]) * $signed(t4_reg[2]);
        pa_reg[2] <= $signed(u4_reg[0]) * $signed(t4_reg[1]);
        pb_reg[2] <= $signed(u4_reg[1]) * $signed(t4_reg[0]);
        tmx1_reg <= tm4_reg;
        tnx1_reg <= tn4_reg;
        sbx1_reg <= sb4t_reg;

        for (int i = 0; i < NL; i++)
        begin
            sd   = pa_reg[i] - pb_reg[i];
            smag = sd[63] ? (~sd + 1'b1) : sd;
            rs   = smag + (64'd1 << (UB - 1));
            nm2_reg[i] <= rs[UB+31:UB];
            nn2_reg[i] <= sd[63];
        end
        tmx2_reg <= tmx1_reg;
        tnx2_reg <= tnx1_reg;
        sbx2_reg <= sbx1_reg;
    end

    // r1: radius products, r2: round, clamp, zero-length override
    logic [NL-1:0][PW-1:0] ps_reg, pn_reg;
    logic [NL-1:0]         psn_reg, pnn_reg;
    sb_t                   sbr1_reg;
    logic [W-1:0] side_reg [NL];
    logic [W-1:0] span_reg [NL];
    logic [W-1:0] norm_reg [NL];
    logic [W-1:0] ctr_reg  [NL];
    logic         zero_out_reg;

    always_ff @(posedge clk)
    begin
        logic [PW:0] rsum;
        for (int i = 0; i < NL; i++)
        begin
            ps_reg[i] <= PW'({1'b0, tmx2_reg[i]}) * PW'(sbx2_reg.rad);
            pn_reg[i] <= PW'(nm2_reg[i]) * PW'(sbx2_reg.rad);
        end
        psn_reg  <= tnx2_reg;
        pnn_reg  <= nn2_reg;
        sbr1_reg <= sbx2_reg;

        for (int i = 0; i < NL; i++)
        begin
            ctr_reg[i] <= sbr1_reg.ctr[i];
            if (sbr1_reg.zero)
            begin
                side_reg[i] <= (i == 0) ? {1'b0, sbr1_reg.rad} : '0;
                norm_reg[i] <= (i == 2) ? {1'b0, sbr1_reg.rad} : '0;
                span_reg[i] <= (i == 1) ? SPAN_ONE : '0;
            end
            else
            begin
                rsum = {1'b0, ps_reg[i]} + (PW+1)'(64'd1 << (UB - 1));
                side_reg[i] <= sat_mag(rsum[PW:UB], psn_reg[i]);
                rsum = {1'b0, pn_reg[i]} + (PW+1)'(64'd1 << (UB - 1));
                norm_reg[i] <= sat_mag(rsum[PW:UB], pnn_reg[i]);
                span_reg[i] <= sbr1_reg.span[i];
            end
        end
        zero_out_reg <= sbr1_reg.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            vd0_reg  <= 1'b0;
            vt1_reg  <= 1'b0;
            vt2_reg  <= 1'b0;
            vt3_reg  <= 1'b0;
            vd2_reg  <= 1'b0;
            vt4_reg  <= 1'b0;
            vx1_reg  <= 1'b0;
            vx2_reg  <= 1'b0;
            vr1_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= acc;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            vd0_reg  <= vq1;
            vt1_reg  <= vdv1;
            vt2_reg  <= vt1_reg;
            vt3_reg  <= vt2_reg;
            vd2_reg  <= vq2;
            vt4_reg  <= vdv2;
            vx1_reg  <= vt4_reg;
            vx2_reg  <= vx1_reg;
            vr1_reg  <= vx2_reg;
            done_reg <= vr1_reg;
        end
    end

    assign done     = done_reg;
    assign side_x   = side_reg[0];
    assign side_y   = side_reg[1];
    assign side_z   = side_reg[2];
    assign span_x   = span_reg[0];
    assign span_y   = span_reg[1];
    assign span_z   = span_reg[2];
    assign normal_x = norm_reg[0];
    assign normal_y = norm_reg[1];
    assign normal_z = norm_reg[2];
    assign center_x = ctr_reg[0];
    assign center_y = ctr_reg[1];
    assign center_z = ctr_reg[2];

    // a rescaled nonzero segment always has length of at least 2^29
    a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (vq1 && !lsb_q1.sb.zero) |-> (q1_root[RW] >= (RW'(1) << (UB - 1))))
        else $error("direction length below normalized floor");

    // unit direction components never exceed one
    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vdv1 && !sb_dv1.zero) |-> ((dv1_quo[RW][0] <= stcb_pkg::UNIT_ONE)
            && (dv1_quo[RW][1] <= stcb_pkg::UNIT_ONE)
            && (dv1_quo[RW][2] <= stcb_pkg::UNIT_ONE)))
        else $error("unit direction component above one");

    // zero-length beat leaves with the fixed identity-like columns
    a_zero_cols: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_out_reg) |-> ((span_y == SPAN_ONE) && (side_y == '0)
            && (normal_x == '0) && (side_x == normal_z)))
        else $error("zero-length beat columns wrong");

endmodule

@@ dv/segment_to_cylinder_basis_check.sv @@
module segment_to_cylinder_basis_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] start_z,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [31:0] end_z,
    input  logic [30:0] tube_radius,
    input  logic        done,
    input  logic [31:0] side_x,
    input  logic [31:0] side_y,
    input  logic [31:0] side_z,
    input  logic [31:0] span_x,
    input  logic [31:0] span_y,
    input  logic [31:0] span_z,
    input  logic [31:0] normal_x,
    input  logic [31:0] normal_y,
    input  logic [31:0] normal_z,
    input  logic [31:0] center_x,
    input  logic [31:0] center_y,
    input  logic [31:0] center_z,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [11:0][31:0] basis_t;
    typedef longint unsigned u64_t;

    localparam u64_t UNIT = 64'd1 << 30;
    localparam u64_t Y_LIM = (UNIT * 64'd999) / 64'd1000;
    localparam u64_t T_EPS = (64'd1 << 60) / 64'd1000000000000;

    basis_t basis_q[$];
    string  field_name [12] = '{"side_x", "side_y", "side_z", "span_x", "span_y", "span_z",
                                "normal_x", "normal_y", "normal_z",
                                "center_x", "center_y", "center_z"};

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic u64_t magn(longint v);
        return v < 0 ? u64_t'(-v) : u64_t'(v);
    endfunction

    function automatic longint signed_of(u64_t m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic u64_t root_floor(u64_t x);
        u64_t res;
        u64_t b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_quot(longint v, u64_t den);
        return signed_of((magn(v) * UNIT + den / 2) / den, v < 0);
    endfunction

    function automatic longint radius_mul(longint u, u64_t r);
        u64_t ub;
        u64_t p1;
        u64_t p0;
        ub = magn(u);
        p1 = (r >> 24) * ub;
        p0 = (r & 64'hffffff) * ub + (64'd1 << 29);
        return signed_of((p1 >> 6) + ((((p1 & 64'd63) << 24) + p0) >> 30), u < 0);
    endfunction

    function automatic longint cross_q30(longint a, longint b, longint c, longint d);
        longint s;
        s = a * b - c * d;
        return signed_of((magn(s) + (64'd1 << 29)) >> 30, s < 0);
    endfunction

    function automatic basis_t predict_basis(logic [5:0][31:0] pts, logic [30:0] rad);
        basis_t o;
        longint sp [3];
        longint ep [3];
        longint d [3];
        longint u [3];
        longint t [3];
        longint n [3];
        longint sum;
        u64_t   r;
        u64_t   mx;
        u64_t   m;
        u64_t   a;
        u64_t   len;
        u64_t   tsq;
        int     up;
        int     down;
        r = u64_t'(rad);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            sp[i] = longint'($signed(pts[i]));
            ep[i] = longint'($signed(pts[i + 3]));
            d[i] = ep[i] - sp[i];
            sum = sp[i] + ep[i];
            o[9 + i] = clamp32(sum >= 0 ? sum / 2 : -((-sum + 1) / 2));
            if (magn(d[i]) > mx) mx = magn(d[i]);
        end
        // threshold rounds to zero at 16 fractional bits: only an exact zero degenerates
        if (mx == 0) begin
            o[0] = clamp32(longint'(r));
            o[1] = 0;
            o[2] = 0;
            o[3] = 0;
            o[4] = 32'h00010000;
            o[5] = 0;
            o[6] = 0;
            o[7] = 0;
            o[8] = clamp32(longint'(r));
            return o;
        end
        for (int i = 0; i < 3; i++) o[3 + i] = clamp32(d[i]);
        up = 0;
        down = 0;
        m = mx;
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            up++;
        end
        while (m >= UNIT) begin
            m >>= 1;
            down++;
        end
        for (int i = 0; i < 3; i++) begin
            a = magn(d[i]);
            a = (up != 0) ? (a << up) : (a >> down);
            d[i] = signed_of(a, d[i] < 0);
        end
        len = root_floor(magn(d[0]) ** 2 + magn(d[1]) ** 2 + magn(d[2]) ** 2);
        for (int i = 0; i < 3; i++) u[i] = unit_quot(d[i], len);
        if (magn(u[1]) <= Y_LIM) begin
            t[0] = u[2];
            t[1] = 0;
            t[2] = -u[0];
        end else begin
            t[0] = 0;
            t[1] = -u[2];
            t[2] = u[1];
        end
        tsq = magn(t[0]) ** 2 + magn(t[1]) ** 2 + magn(t[2]) ** 2;
        if (tsq > T_EPS) begin
            len = root_floor(tsq);
            for (int i = 0; i < 3; i++) t[i] = unit_quot(t[i], len);
        end else begin
            t[0] = longint'(UNIT);
            t[1] = 0;
            t[2] = 0;
        end
        n[0] = cross_q30(u[1], t[2], u[2], t[1]);
        n[1] = cross_q30(u[2], t[0], u[0], t[2]);
        n[2] = cross_q30(u[0], t[1], u[1], t[0]);
        for (int i = 0; i < 3; i++) begin
            o[i] = clamp32(radius_mul(t[i], r));
            o[6 + i] = clamp32(radius_mul(n[i], r));
        end
        return o;
    endfunction

    assign pending = basis_q.size();

    always @(posedge clk or negedge rst_n) begin
        basis_t got;
        basis_t want;
        bit     bad;
        if (!rst_n) begin
            errors <= 0;
        end else begin
            if (start && !busy)
                basis_q.push_back(predict_basis({end_z, end_y, end_x, start_z, start_y, start_x},
                                                tube_radius));
            if (done) begin
                got = {center_z, center_y, center_x, normal_z, normal_y, normal_x,
                       span_z, span_y, span_x, side_z, side_y, side_x};
                if (basis_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result beat at %0t", $realtime);
                    errors <= errors + 1;
                end else begin
                    want = basis_q.pop_front();
                    bad = 0;
                    for (int i = 0; i < 12; i++) begin
                        if (got[i] !== want[i]) begin
                            bad = 1;
                            if (errors < 10)
                                $display("mismatch %s: expected %h actual %h",
                                         field_name[i], want[i], got[i]);
                        end
                    end
                    if (bad) errors <= errors + 1;
                end
            end
        end
    end
endmodule

@@ dv/segment_to_cylinder_basis_test.sv @@
module segment_to_cylinder_basis_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic [30:0] tube_radius;
    logic        done;
    logic [31:0] side_x, side_y, side_z, span_x, span_y, span_z;
    logic [31:0] normal_x, normal_y, normal_z, center_x, center_y, center_z;
    int          errors;
    int          pending;
    int          quiet_cycles;

    segment_to_cylinder_basis u_dut (.*);
    segment_to_cylinder_basis_check u_check (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 3000) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                             logic [30:0] r);
        start <= 1;
        start_x <= sx;
        start_y <= sy;
        start_z <= sz;
        end_x <= ex;
        end_y <= ey;
        end_z <= ez;
        tube_radius <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_burst();
        start <= 0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
    endtask

    function automatic logic [31:0] small_coord();
        return 32'($signed($urandom_range(2000000, 0)) - 1000000);
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(5, 0))
            0: return 31'h0;
            1: return 31'h7fffffff;
            2: return 31'($urandom_range(1 << 20, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] sx, sy, sz, ex, ey, ez;
        bit          idling;
        rst_n = 0;
        start = 0;
        {start_x, start_y, start_z, end_x, end_y, end_z} = '0;
        tube_radius = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero length, with the midpoint at the corners of the range
        send_beat(0, 0, 0, 0, 0, 0, 31'h10000);
        send_beat(32'h7fffffff, 32'h80000000, 32'hffffffff,
                  32'h7fffffff, 32'h80000000, 32'hffffffff, 31'h7fffffff);
        // axis directions, including both vertical ones
        send_beat(0, 0, 0, 32'h10000, 0, 0, 31'h10000);
        send_beat(0, 0, 0, 0, 32'h10000, 0, 31'h10000);
        send_beat(0, 0, 0, 0, 32'hffff0000, 0, 31'h28000);
        send_beat(0, 0, 0, 0, 0, 32'h10000, 31'h10000);
        send_beat(0, 0, 0, 32'hffffffff, 0, 0, 31'h7fffffff);
        // near vertical, all on the vertical side of the switch
        send_beat(0, 0, 0, 32'h00000b50, 32'h10000, 0, 31'h30000);
        send_beat(0, 0, 0, 32'h00000b40, 32'h10000, 0, 31'h30000);
        send_beat(0, 0, 0, 32'h10, 32'h7fff0000, 32'h10, 31'h10000);
        // span saturation both ways
        send_beat(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        send_beat(32'h7fffffff, 32'h0, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h1);
        send_beat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 31'h0);
        send_beat(0, 0, 0, 32'h1, 32'h1, 32'h1, 31'h10000);
        send_beat(32'hffffffff, 0, 0, 0, 0, 0, 31'h10000);
        send_beat(32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
                  32'h87654321, 32'h13579bdf, 32'hf0f0f0f0, 31'h55555555);

        for (int n = 0; n < 900; n++) begin
            sx = small_coord();
            sy = small_coord();
            sz = small_coord();
            case ($urandom_range(9, 0))
                0: {sx, sy, sz, ex, ey, ez} = {$urandom, $urandom, $urandom,
                                               $urandom, $urandom, $urandom};
                1: {ex, ey, ez} = {sx, sy, sz};
                2: {ex, ey, ez} = {sx + 32'($urandom_range(64, 0)) - 32,
                                   sy + $urandom,
                                   sz + 32'($urandom_range(64, 0)) - 32};
                3: {ex, ey, ez} = {sx + 32'($urandom_range(8, 0)) - 4,
                                   sy + 32'($urandom_range(8, 0)) - 4,
                                   sz + 32'($urandom_range(8, 0)) - 4};
                4: {ex, ey, ez} = {sx, sy, sz + $urandom};
                default: {ex, ey, ez} = {small_coord(), small_coord(), small_coord()};
            endcase
            idling = (n < 750) && ($urandom_range(3, 0) == 0);
            if (idling) idle_burst();
            send_beat(sx, sy, sz, ex, ey, ez, rand_radius());
        end
        start <= 0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
